FILE: rtl/edc_pkg.sv
`timescale 1ns / 1ps

package edc_pkg;

  localparam int VW    = 16;          // velocity and offset width
  localparam int DIFW  = VW + 1;      // velocity difference
  localparam int PRODW = DIFW + VW;   // difference times offset
  localparam int DOTW  = PRODW + 1;   // dot product
  localparam int SQW   = 2 * VW - 1;  // square of one offset component
  localparam int LENW  = SQW + 1;     // squared length
  localparam int NUMW  = DOTW + VW;   // dot times offset, and divider remainder
  // |delta| <= |vel_b - vel_a| < 2^16 * sqrt(2), rounding included
  localparam int QW    = 17;
  localparam int DLYW  = QW + 1;      // signed delta
  localparam int SUMW  = DLYW + 1;    // velocity plus delta before saturation
  localparam int IN_W  = 6 * VW;
  localparam int OUT_W = 4 * VW;

  typedef logic signed [VW-1:0] vel_t;

  typedef struct packed {
    vel_t ax;
    vel_t ay;
    vel_t bx;
    vel_t by;
  } vel_set_t;

  typedef struct packed {
    vel_set_t vel;
    logic     skip;
    logic     neg_x;
    logic     neg_y;
  } side_t;

  typedef struct packed {
    logic [NUMW-1:0] rem_x;
    logic [NUMW-1:0] rem_y;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic [LENW-1:0] len2;
    side_t           side;
  } div_stage_t;

  typedef struct packed {
    vel_t ax;
    vel_t ay;
    vel_t bx;
    vel_t by;
    logic skip;
  } result_t;

endpackage

FILE: rtl/edc_front.sv
`timescale 1ns / 1ps

module edc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  edc_pkg::vel_set_t            in_vel,
  input  logic signed [edc_pkg::VW-1:0] in_off_x,
  input  logic signed [edc_pkg::VW-1:0] in_off_y,
  output logic                         out_valid,
  output edc_pkg::div_stage_t          out_stage
);
  import edc_pkg::*;

  logic                   v1, v2, v3, v4;
  vel_set_t               vel1, vel2, vel3, vel4;
  logic signed [VW-1:0]   ox1, oy1, ox2, oy2, ox3, oy3;
  logic signed [DIFW-1:0] dvx1, dvy1;
  logic signed [PRODW-1:0] px2, py2;
  logic [SQW-1:0]         sqx2, sqy2;
  logic signed [DOTW-1:0] dot3;
  logic [LENW-1:0]        len3, len4;
  logic                   skip3, skip4;
  logic signed [NUMW-1:0] nx4, ny4;

  logic signed [LENW-1:0] sqx_full, sqy_full;
  logic [NUMW-1:0]        magx, magy;

  assign sqx_full = ox1 * ox1;
  assign sqy_full = oy1 * oy1;

  always_comb begin
    magx = nx4[NUMW-1] ? -nx4 : nx4;
    magy = ny4[NUMW-1] ? -ny4 : ny4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // velocity difference
      vel1 <= in_vel;
      ox1  <= in_off_x;
      oy1  <= in_off_y;
      dvx1 <= DIFW'(in_vel.bx) - DIFW'(in_vel.ax);
      dvy1 <= DIFW'(in_vel.by) - DIFW'(in_vel.ay);
      // products
      vel2 <= vel1;
      ox2  <= ox1;
      oy2  <= oy1;
      px2  <= dvx1 * ox1;
      py2  <= dvy1 * oy1;
      sqx2 <= sqx_full[SQW-1:0];
      sqy2 <= sqy_full[SQW-1:0];
      // dot product and squared length
      vel3  <= vel2;
      ox3   <= ox2;
      oy3   <= oy2;
      dot3  <= DOTW'(px2) + DOTW'(py2);
      len3  <= LENW'(sqx2) + LENW'(sqy2);
      skip3 <= (ox2 == '0) && (oy2 == '0);
      // scale by offset
      vel4  <= vel3;
      nx4   <= dot3 * ox3;
      ny4   <= dot3 * oy3;
      len4  <= len3;
      skip4 <= skip3;
      // magnitudes plus half divisor for round to nearest
      out_stage.rem_x      <= magx + NUMW'(len4 >> 1);
      out_stage.rem_y      <= magy + NUMW'(len4 >> 1);
      out_stage.q_x        <= '0;
      out_stage.q_y        <= '0;
      out_stage.len2       <= len4;
      out_stage.side.vel   <= vel4;
      out_stage.side.skip  <= skip4;
      out_stage.side.neg_x <= nx4[NUMW-1];
      out_stage.side.neg_y <= ny4[NUMW-1];
    end
  end

endmodule

FILE: rtl/edc_div.sv
`timescale 1ns / 1ps

// Restoring divide, one quotient bit per stage, x and y lanes side by side.
module edc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  edc_pkg::div_stage_t in_stage,
  output logic                out_valid,
  output edc_pkg::div_stage_t out_stage
);
  import edc_pkg::*;

  logic [QW-1:0] vld;
  div_stage_t    stg [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int K = QW - 1 - i;
    div_stage_t      cur;
    div_stage_t      nxt;
    logic [NUMW-1:0] dsh;
    logic            ge_x, ge_y;

    if (i == 0) begin : g_first
      assign cur = in_stage;
    end else begin : g_rest
      assign cur = stg[i-1];
    end

    always_comb begin
      dsh  = NUMW'(cur.len2) << K;
      ge_x = cur.rem_x >= dsh;
      ge_y = cur.rem_y >= dsh;
      nxt  = cur;
      if (ge_x) begin
        nxt.rem_x = cur.rem_x - dsh;
      end
      if (ge_y) begin
        nxt.rem_y = cur.rem_y - dsh;
      end
      nxt.q_x[K] = ge_x;
      nxt.q_y[K] = ge_y;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[i] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  assign out_valid = vld[QW-1];
  assign out_stage = stg[QW-1];

endmodule

FILE: rtl/edc_out.sv
`timescale 1ns / 1ps

// Apply signed delta and saturate unless skipped, then output register with a one-word skid.
module edc_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  edc_pkg::div_stage_t in_stage,
  output logic                adv,
  output logic                m_tvalid,
  input  logic                m_tready,
  output edc_pkg::result_t    m_res
);
  import edc_pkg::*;

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(2 ** (VW - 1) - 1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  function automatic vel_t sat(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] r;
    priority if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r[VW-1:0];
  endfunction

  logic signed [DLYW-1:0] mag_x, mag_y, ex, ey;
  logic signed [SUMW-1:0] sum_ax, sum_ay, sum_bx, sum_by;
  result_t                res_next, skid_res;
  logic                   skid_valid, take;
  vel_set_t               vel;

  assign vel   = in_stage.side.vel;
  assign mag_x = signed'({1'b0, in_stage.q_x});
  assign mag_y = signed'({1'b0, in_stage.q_y});
  assign ex    = in_stage.side.neg_x ? -mag_x : mag_x;
  assign ey    = in_stage.side.neg_y ? -mag_y : mag_y;

  assign sum_ax = SUMW'(vel.ax) + SUMW'(ex);
  assign sum_ay = SUMW'(vel.ay) + SUMW'(ey);
  assign sum_bx = SUMW'(vel.bx) - SUMW'(ex);
  assign sum_by = SUMW'(vel.by) - SUMW'(ey);

  always_comb begin
    if (in_stage.side.skip) begin
      res_next.ax = vel.ax;
      res_next.ay = vel.ay;
      res_next.bx = vel.bx;
      res_next.by = vel.by;
    end else begin
      res_next.ax = sat(sum_ax);
      res_next.ay = sat(sum_ay);
      res_next.bx = sat(sum_bx);
      res_next.by = sat(sum_by);
    end
    res_next.skip = in_stage.side.skip;
  end

  assign adv  = !skid_valid;
  assign take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        m_tvalid <= skid_valid || in_valid;
      end
      if (skid_valid && take) begin
        skid_valid <= 1'b0;
      end else if (!skid_valid && in_valid && !take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_res <= skid_valid ? skid_res : res_next;
    end
    if (!skid_valid && !take) begin
      skid_res <= res_next;
    end
  end

endmodule

FILE: rtl/elastic_disc_collision.sv
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                               tuser
// s_*       in   vel_a_x vel_a_y vel_b_x vel_b_y offset_x offset_y -
// m_*       out  new_a_x new_a_y new_b_x new_b_y                  skipped
//
// One word per clock while the skid word is empty; 5 multiply/sum stages, a 17-stage
// restoring divider (one quotient bit per stage) and one output stage form the pipeline.
// rst is synchronous; it empties the pipeline and the skid word.
// All stages advance together while the skid word is empty; a stalled output
// fills the skid, which holds the pipeline until the output drains.
module elastic_disc_collision (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // vel_a_x, vel_a_y, vel_b_x, vel_b_y, offset_x, offset_y
  input  logic [edc_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // new_a_x, new_a_y, new_b_x, new_b_y
  output logic [edc_pkg::OUT_W-1:0]    m_tdata,
  // skipped
  output logic                         m_tuser
);
  import edc_pkg::*;

  logic                 adv;
  vel_set_t             in_vel;
  logic signed [VW-1:0] off_x, off_y;
  logic                 front_valid, div_valid;
  div_stage_t           front_stage, div_stage;
  result_t              res;

  assign in_vel.ax = s_tdata[VW-1:0];
  assign in_vel.ay = s_tdata[2*VW-1:VW];
  assign in_vel.bx = s_tdata[3*VW-1:2*VW];
  assign in_vel.by = s_tdata[4*VW-1:3*VW];
  assign off_x     = s_tdata[5*VW-1:4*VW];
  assign off_y     = s_tdata[6*VW-1:5*VW];

  assign s_tready = adv;

  edc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid),
    .in_vel    (in_vel),
    .in_off_x  (off_x),
    .in_off_y  (off_y),
    .out_valid (front_valid),
    .out_stage (front_stage)
  );

  edc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .in_stage  (front_stage),
    .out_valid (div_valid),
    .out_stage (div_stage)
  );

  edc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .in_stage (div_stage),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (res)
  );

  assign m_tdata = {res.by, res.bx, res.ay, res.ax};
  assign m_tuser = res.skip;

endmodule

FILE: rtl/edc_checker.sv
`timescale 1ns / 1ps

module edc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [edc_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tuser
);

  // reset leaves the output empty and the input open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output not empty after reset");

  // held output word does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // input closes only after an output stall
  a_close_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(m_tvalid && !m_tready))
    else $error("input closed without an output stall");

  // skid word stays while the output is still stalled
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready && !m_tready |=> !s_tready && m_tvalid)
    else $error("skid word lost during stall");

endmodule

bind elastic_disc_collision edc_checker u_chk (.*);

FILE: tb/sv/edc_checker.sv
`timescale 1ns / 1ps

module edc_scoreboard (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  // vel_a_x, vel_a_y, vel_b_x, vel_b_y, offset_x, offset_y
  input  logic [edc_pkg::IN_W-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  // new_a_x, new_a_y, new_b_x, new_b_y
  input  logic [edc_pkg::OUT_W-1:0] m_tdata,
  // skipped
  input  logic                      m_tuser,
  output int                        fail_count,
  output int                        pending,
  output int                        checked,
  output int                        skip_seen,
  output int                        clip_seen
);
  import edc_pkg::*;

  typedef struct packed {
    vel_t ax;
    vel_t ay;
    vel_t bx;
    vel_t by;
    logic skip;
    logic clipped;
  } rebound_t;

  rebound_t rebound_q [$];
  int fails = 0;
  int matched = 0;
  int skips = 0;
  int clips = 0;

  // nearest integer quotient, ties away from zero; den is positive
  function automatic longint div_nearest(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // project the velocity difference onto the line of centers and exchange it
  function automatic rebound_t collide(input vel_t ax, input vel_t ay, input vel_t bx,
                                       input vel_t by, input vel_t dx, input vel_t dy);
    rebound_t r;
    longint len2;
    longint dot;
    longint ex;
    longint ey;
    longint sum [4];
    r.skip = 1'b0;
    r.clipped = 1'b0;
    len2 = longint'(dx) * dx + longint'(dy) * dy;
    if (len2 == 0) begin
      r.ax = ax;
      r.ay = ay;
      r.bx = bx;
      r.by = by;
      r.skip = 1'b1;
      return r;
    end
    dot = (longint'(bx) - ax) * dx + (longint'(by) - ay) * dy;
    ex = div_nearest(dot * dx, len2);
    ey = div_nearest(dot * dy, len2);
    sum[0] = longint'(ax) + ex;
    sum[1] = longint'(ay) + ey;
    sum[2] = longint'(bx) - ex;
    sum[3] = longint'(by) - ey;
    for (int i = 0; i < 4; i++) begin
      if (sum[i] > 32767) begin
        sum[i] = 32767;
        r.clipped = 1'b1;
      end else if (sum[i] < -32768) begin
        sum[i] = -32768;
        r.clipped = 1'b1;
      end
    end
    r.ax = vel_t'(sum[0]);
    r.ay = vel_t'(sum[1]);
    r.bx = vel_t'(sum[2]);
    r.by = vel_t'(sum[3]);
    return r;
  endfunction

  always @(posedge clk) begin
    rebound_t want;
    rebound_t got;
    if (rst) begin
      rebound_q.delete();
    end else begin
      // retire before queuing, so a stray word never pairs with a same-cycle input
      if (m_tvalid && m_tready) begin
        got.ax = vel_t'(m_tdata[0*VW +: VW]);
        got.ay = vel_t'(m_tdata[1*VW +: VW]);
        got.bx = vel_t'(m_tdata[2*VW +: VW]);
        got.by = vel_t'(m_tdata[3*VW +: VW]);
        got.skip = m_tuser;
        got.clipped = 1'b0;
        if (rebound_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected word: a=(%0d,%0d) b=(%0d,%0d) skipped=%0b",
                     $realtime, got.ax, got.ay, got.bx, got.by, got.skip);
        end else begin
          want = rebound_q.pop_front();
          matched++;
          if (want.skip) skips++;
          if (want.clipped) clips++;
          if (got.ax !== want.ax || got.ay !== want.ay || got.bx !== want.bx ||
              got.by !== want.by || got.skip !== want.skip) begin
            fails++;
            if (fails <= 10)
              $display({"[%0t] mismatch on word %0d: expected a=(%0d,%0d) b=(%0d,%0d) ",
                        "skipped=%0b, got a=(%0d,%0d) b=(%0d,%0d) skipped=%0b"},
                       $realtime, matched, want.ax, want.ay, want.bx, want.by, want.skip,
                       got.ax, got.ay, got.bx, got.by, got.skip);
          end
        end
      end
      if (s_tvalid && s_tready)
        rebound_q.push_back(collide(vel_t'(s_tdata[0*VW +: VW]), vel_t'(s_tdata[1*VW +: VW]),
                                    vel_t'(s_tdata[2*VW +: VW]), vel_t'(s_tdata[3*VW +: VW]),
                                    vel_t'(s_tdata[4*VW +: VW]), vel_t'(s_tdata[5*VW +: VW])));
    end
    fail_count <= fails;
    pending    <= rebound_q.size();
    checked    <= matched;
    skip_seen  <= skips;
    clip_seen  <= clips;
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import edc_pkg::*;

  localparam int RANDOM_PAIRS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_WAIT   = 40;   // pipeline is 23 deep plus the skid word

  typedef struct packed {
    vel_t dy;
    vel_t dx;
    vel_t by;
    vel_t bx;
    vel_t ay;
    vel_t ax;
  } disc_pair_t;

  typedef enum int {SPAN_FULL, SPAN_SMALL, SPAN_EDGE} span_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE, RX_PULSE} rx_mode_e;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;

  int fail_count;
  int pending;
  int checked;
  int skip_seen;
  int clip_seen;

  int          burst_left = 0;
  int          sent = 0;
  int unsigned cycles = 0;

  elastic_disc_collision dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  edc_scoreboard u_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .skip_seen  (skip_seen),
    .clip_seen  (clip_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles, pending);
      $display("elastic_disc_collision test failed");
      $finish;
    end
  end

  // output side: stall pattern picks a new random mode each time its run ends
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      case ($urandom_range(0, 3))
        0: rx_mode = RX_OPEN;
        1: rx_mode = RX_COIN;
        2: rx_mode = RX_CHOKE;
        default: rx_mode = RX_PULSE;
      endcase
      rx_left = $urandom_range(50, 400);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  m_tready <= 1'b1;
      RX_COIN:  m_tready <= ($urandom_range(0, 1) == 1);
      RX_CHOKE: m_tready <= ($urandom_range(0, 5) == 0);
      default:  m_tready <= ((cycles % 9) < 5);
    endcase
  end

  function automatic vel_t pick_vel(input span_e span);
    case (span)
      SPAN_FULL:  return vel_t'($urandom);
      SPAN_SMALL: return vel_t'(int'($urandom_range(0, 4096)) - 2048);
      default: begin
        case ($urandom_range(0, 4))
          0: return vel_t'(-32768);
          1: return vel_t'(32767);
          2: return vel_t'(-1);
          3: return vel_t'(1);
          default: return vel_t'(0);
        endcase
      end
    endcase
  endfunction

  function automatic disc_pair_t random_pair();
    disc_pair_t p;
    span_e      span;
    int         r;
    r = $urandom_range(0, 9);
    if (r < 4) span = SPAN_FULL;
    else if (r < 8) span = SPAN_SMALL;
    else span = SPAN_EDGE;
    p.ax = pick_vel(span);
    p.ay = pick_vel(span);
    p.bx = pick_vel(span);
    p.by = pick_vel(span);
    // equal velocities: nothing to exchange
    if ($urandom_range(0, 19) == 0) begin
      p.bx = p.ax;
      p.by = p.ay;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      p.dx = '0;
      p.dy = '0;
    end else if (r < 30) begin
      p.dx = pick_vel(SPAN_FULL);
      p.dy = pick_vel(SPAN_FULL);
    end else if (r < 60) begin
      p.dx = vel_t'(int'($urandom_range(0, 128)) - 64);
      p.dy = vel_t'(int'($urandom_range(0, 128)) - 64);
    end else if (r < 80) begin
      // along one axis
      p.dx = ($urandom_range(0, 1) == 1) ? pick_vel(SPAN_FULL) : pick_vel(SPAN_SMALL);
      p.dy = '0;
      if ($urandom_range(0, 1) == 1) begin
        p.dy = p.dx;
        p.dx = '0;
      end
    end else begin
      p.dx = pick_vel(SPAN_EDGE);
      p.dy = pick_vel(SPAN_EDGE);
    end
    return p;
  endfunction

  task automatic push_pair(input disc_pair_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tdata  <= p;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // ax, ay, bx, by, offset_x, offset_y
  int corner [18][6] = '{
    '{0, 0, 0, 0, 0, 0},
    '{32767, -32768, -32768, 32767, 0, 0},
    '{256, 0, -256, 0, 1, 0},
    '{0, 300, 0, -100, 0, -1},
    '{128, -64, -512, 77, 32767, 32767},
    '{1000, -2000, -3000, 4000, -32768, -32768},
    '{-5000, 123, 7000, -321, -32768, 0},
    '{32767, 32767, 32767, -32768, 1, 1},      // clips high
    '{-32768, -32768, -32768, 32767, 1, 1},    // clips low
    '{0, 0, 1, 0, 1, 1},                       // half step, rounds up
    '{0, 0, -1, 0, 1, 1},                      // half step, rounds down
    '{0, 0, 256, 0, 16, 0},                    // second disc comes to rest
    '{0, 256, 0, -256, 16, 0},                 // purely tangential
    '{-700, 900, 300, -50, -1, 0},
    '{512, -256, -128, 640, 48, 64},
    '{32767, 32767, -32768, -32768, 32767, -32768},
    '{-32768, 32767, 32767, -32768, -32767, 32767},
    '{1, -1, -1, 1, -32768, 32767}
  };

  initial begin
    disc_pair_t p;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 18; i++) begin
      p.ax = vel_t'(corner[i][0]);
      p.ay = vel_t'(corner[i][1]);
      p.bx = vel_t'(corner[i][2]);
      p.by = vel_t'(corner[i][3]);
      p.dx = vel_t'(corner[i][4]);
      p.dy = vel_t'(corner[i][5]);
      push_pair(p);
    end
    wait_drained();

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == 500 || i == 1000) wait_drained();
      push_pair(random_pair());
    end
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d disc pairs (18 corner cases), %0d results checked", sent, checked);
    $display("%0d zero-offset pass-throughs, %0d results clipped to 16 bits",
             skip_seen, clip_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("elastic_disc_collision test passed");
    end else begin
      $display("%0d failures, %0d words never arrived", fail_count, pending);
      $display("elastic_disc_collision test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/edc_pkg.sv
rtl/edc_front.sv
rtl/edc_div.sv
rtl/edc_out.sv
rtl/elastic_disc_collision.sv
rtl/edc_checker.sv
tb/sv/edc_checker.sv
tb/sv/tb.sv
